### sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types and constants of the controller frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

    typedef enum logic [1:0]
    {
        PH_START,
        PH_BETWEEN,
        PH_FRAME,
        PH_SKIP
    } phase_t;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    // frame kinds
    localparam logic [2:0] KIND_BUTTON = 3'd0;
    localparam logic [2:0] KIND_COLOR  = 3'd1;
    localparam logic [2:0] KIND_ACCEL  = 3'd2;
    localparam logic [2:0] KIND_MAGNET = 3'd3;
    localparam logic [2:0] KIND_QUAT   = 3'd4;
    localparam logic [2:0] KIND_GYRO   = 3'd5;
    localparam logic [2:0] KIND_LOC    = 3'd6;

    // characters
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_Q     = 8'h51;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // frame lengths including start and checksum bytes
    localparam logic [3:0] LEN_BUTTON = 4'd5;
    localparam logic [3:0] LEN_COLOR  = 4'd6;
    localparam logic [3:0] LEN_SENSOR = 4'd9;
    localparam logic [3:0] LEN_QUAT   = 4'd11;

    typedef struct packed
    {
        logic [7:0] rx_byte;
        logic       buffer_last;
    } in_word_t;

    typedef struct packed
    {
        logic        frame_valid;
        logic [2:0]  frame_kind;
        logic [7:0]  button_number;
        logic        button_pressed;
        logic [23:0] color_value;
        logic [2:0]  error_code;
        logic        buffer_done;
        logic        buffer_ok;
    } result_t;

    typedef struct packed
    {
        logic       known;
        logic [2:0] kind;
        logic [3:0] length;
    } type_info_t;

    function automatic type_info_t type_lookup(input logic [7:0] letter);
        type_info_t info;
        info.known  = 1'b1;
        info.kind   = KIND_BUTTON;
        info.length = 4'd0;
        unique case (letter)
            CHAR_B:
            begin
                info.kind   = KIND_BUTTON;
                info.length = LEN_BUTTON;
            end
            CHAR_C:
            begin
                info.kind   = KIND_COLOR;
                info.length = LEN_COLOR;
            end
            CHAR_A:
            begin
                info.kind   = KIND_ACCEL;
                info.length = LEN_SENSOR;
            end
            CHAR_M:
            begin
                info.kind   = KIND_MAGNET;
                info.length = LEN_SENSOR;
            end
            CHAR_Q:
            begin
                info.kind   = KIND_QUAT;
                info.length = LEN_QUAT;
            end
            CHAR_G:
            begin
                info.kind   = KIND_GYRO;
                info.length = LEN_SENSOR;
            end
            CHAR_L:
            begin
                info.kind   = KIND_LOC;
                info.length = LEN_SENSOR;
            end
            default:
            begin
                info.known = 1'b0;
            end
        endcase
        return info;
    endfunction

endpackage

### sv/controller_frame_parser.sv
// ----------------------------------------------------------------------------
// controller_frame_parser
// path: an accepted byte is held in the input register, and its result, if any,
//   is then loaded into the result register
// throughput: one byte per cycle while the consumer keeps out_ready high
// reset: rst_n clears all parser state and both valid flags; the parser then
//   expects the start of a new receive buffer
// ----------------------------------------------------------------------------
module controller_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        buffer_last,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_valid,
    output logic [2:0]  frame_kind,
    output logic [7:0]  button_number,
    output logic        button_pressed,
    output logic [23:0] color_value,
    output logic [2:0]  error_code,
    output logic        buffer_done,
    output logic        buffer_ok
);
    import cfp_pkg::*;

    logic     hold_valid;
    in_word_t hold_word;
    logic     advance;
    logic     emit;
    result_t  step_result;
    result_t  held;

    // a held word moves on when the result slot is free or being drained;
    // words that give no result still step the parser and leave the slot empty
    assign advance = hold_valid && (!out_valid || out_ready);

    // input register: one word deep, refilled in the same cycle it drains
    cfp_input_reg u_input
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .buffer_last (buffer_last),
        .advance     (advance),
        .hold_valid  (hold_valid),
        .hold_word   (hold_word)
    );

    // frame parser: phase, position, checksum and captured payload
    cfp_parse_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (hold_word),
        .emit   (emit),
        .result (step_result)
    );

    // result register toward the consumer
    cfp_result_reg u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .emit      (emit),
        .result    (step_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .held      (held)
    );

    assign frame_valid    = held.frame_valid;
    assign frame_kind     = held.frame_kind;
    assign button_number  = held.button_number;
    assign button_pressed = held.button_pressed;
    assign color_value    = held.color_value;
    assign error_code     = held.error_code;
    assign buffer_done    = held.buffer_done;
    assign buffer_ok      = held.buffer_ok;

endmodule

### sv/cfp_input_reg.sv
// ----------------------------------------------------------------------------
// cfp_input_reg
// input register stage, takes a new word whenever the stage is empty or drains
// ----------------------------------------------------------------------------
module cfp_input_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               buffer_last,
    input  logic               advance,
    output logic               hold_valid,
    output cfp_pkg::in_word_t  hold_word
);
    import cfp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg.rx_byte     <= rx_byte;
            word_reg.buffer_last <= buffer_last;
        end
    end

endmodule

### sv/cfp_parse_core.sv
// ----------------------------------------------------------------------------
// cfp_parse_core
// parser state and the per-byte step that updates it
// ----------------------------------------------------------------------------
module cfp_parse_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  cfp_pkg::in_word_t  word,
    output logic               emit,
    output cfp_pkg::result_t   result
);
    import cfp_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  pos_reg,     pos_next;
    logic [3:0]  len_reg,     len_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [2:0]  kind_reg,    kind_next;
    logic [7:0]  digit_reg,   digit_next;
    logic        press_reg,   press_next;
    logic [23:0] color_reg,   color_next;
    logic        latched_reg, latched_next;

    logic [7:0]  b;
    logic        last;
    logic [2:0]  err;
    logic        good;
    type_info_t  info;

    assign b    = word.rx_byte;
    assign last = word.buffer_last;
    assign info = type_lookup(b);

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        kind_next    = kind_reg;
        digit_next   = digit_reg;
        press_next   = press_reg;
        color_next   = color_reg;
        latched_next = latched_reg;
        err          = ERR_NONE;
        good         = 1'b0;
        emit         = 1'b0;
        result       = '0;

        unique case (phase_reg)
            PH_START, PH_BETWEEN:
            begin
                if (phase_reg == PH_BETWEEN && (b == CHAR_CR || b == CHAR_LF))
                begin
                    // line ending between frames
                end
                else if (b == CHAR_BANG)
                begin
                    phase_next = PH_FRAME;
                    pos_next   = 4'd1;
                    len_next   = 4'd0;
                    sum_next   = CHAR_BANG;
                    kind_next  = KIND_BUTTON;
                    digit_next = 8'd0;
                    press_next = 1'b0;
                    color_next = 24'd0;
                end
                else
                begin
                    err = ERR_BAD_START;
                end
            end
            PH_FRAME:
            begin
                if (pos_reg == 4'd1)
                begin
                    if (info.known)
                    begin
                        kind_next = info.kind;
                        len_next  = info.length;
                        sum_next  = sum_reg + b;
                        pos_next  = 4'd2;
                    end
                    else
                    begin
                        err = ERR_BAD_TYPE;
                    end
                end
                else if ({1'b0, pos_reg} + 5'd1 < {1'b0, len_reg})
                begin
                    if (kind_reg == KIND_BUTTON)
                    begin
                        if (pos_reg == 4'd2)
                        begin
                            digit_next = b - CHAR_ZERO;
                        end
                        else if (pos_reg == 4'd3)
                        begin
                            press_next = (b == CHAR_ONE);
                        end
                    end
                    else if (kind_reg == KIND_COLOR)
                    begin
                        color_next = {color_reg[15:0], b};
                    end
                    sum_next = sum_reg + b;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    if (b == ~sum_reg)
                    begin
                        good       = 1'b1;
                        emit       = 1'b1;
                        phase_next = PH_BETWEEN;
                    end
                    else
                    begin
                        err = ERR_CHECKSUM;
                    end
                end
                if (err == ERR_NONE && !good && last)
                begin
                    err = ERR_TRUNCATED;
                end
            end
            PH_SKIP:
            begin
                // rest of buffer ignored
            end
            default:
            begin
            end
        endcase

        if (err != ERR_NONE)
        begin
            latched_next = 1'b1;
            phase_next   = PH_SKIP;
            emit         = 1'b1;
        end

        if (good)
        begin
            result.frame_valid = 1'b1;
            result.frame_kind  = kind_reg;
            if (kind_reg == KIND_BUTTON)
            begin
                result.button_number  = digit_reg;
                result.button_pressed = press_reg;
            end
            else if (kind_reg == KIND_COLOR)
            begin
                result.color_value = color_reg;
            end
        end
        result.error_code = err;

        if (last)
        begin
            emit               = 1'b1;
            result.buffer_done = 1'b1;
            result.buffer_ok   = !(latched_reg || err != ERR_NONE);
            phase_next         = PH_START;
            pos_next           = 4'd0;
            len_next           = 4'd0;
            sum_next           = 8'd0;
            latched_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pos_reg     <= 4'd0;
            len_reg     <= 4'd0;
            sum_reg     <= 8'd0;
            kind_reg    <= KIND_BUTTON;
            digit_reg   <= 8'd0;
            press_reg   <= 1'b0;
            color_reg   <= 24'd0;
            latched_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            kind_reg    <= kind_next;
            digit_reg   <= digit_next;
            press_reg   <= press_next;
            color_reg   <= color_next;
            latched_reg <= latched_next;
        end
    end

endmodule

### sv/cfp_result_reg.sv
// ----------------------------------------------------------------------------
// cfp_result_reg
// result register, holds one result until the consumer takes it
// ----------------------------------------------------------------------------
module cfp_result_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              emit,
    input  cfp_pkg::result_t  result,
    input  logic              out_ready,
    output logic              out_valid,
    output cfp_pkg::result_t  held
);
    import cfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_valid = valid_reg;
    assign held      = result_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            result_reg <= result;
        end
    end

endmodule

### sv/cfp_checker.sv
// ----------------------------------------------------------------------------
// cfp_checker
// port-level checks on the frame parser results
// ----------------------------------------------------------------------------
module cfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_valid,
    input logic [2:0]  frame_kind,
    input logic [7:0]  button_number,
    input logic [23:0] color_value,
    input logic [2:0]  error_code,
    input logic        buffer_done,
    input logic        buffer_ok
);
    import cfp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(error_code)
            && $stable(buffer_done) && $stable(frame_valid))
        else $error("stalled result changed");

    // a good frame never carries an error
    a_frame_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> error_code == ERR_NONE)
        else $error("good frame with error code");

    // ok flag only on the closing result, and never with an error
    a_ok_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_ok |-> buffer_done && error_code == ERR_NONE)
        else $error("buffer ok without clean buffer end");

    // no payload without a good frame
    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> frame_kind == KIND_BUTTON
            && button_number == 8'd0 && color_value == 24'd0)
        else $error("payload without good frame");

    // every result is a frame, an error or a buffer end
    a_some_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_valid || buffer_done || error_code != ERR_NONE)
        else $error("empty result");

endmodule

bind controller_frame_parser cfp_checker u_cfp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_valid   (frame_valid),
    .frame_kind    (frame_kind),
    .button_number (button_number),
    .color_value   (color_value),
    .error_code    (error_code),
    .buffer_done   (buffer_done),
    .buffer_ok     (buffer_ok)
);

### test/controller_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// controller_frame_parser_tb
// self-checking bench for the receive-buffer frame parser: button and color
// frames, sensor frames, checksum and framing errors, stray bytes, truncated
// buffers and random noise, all pushed through valid/ready on both sides.
// every accepted word runs through a local parser model; the results it
// predicts are queued and compared field by field with what the block gives
// ----------------------------------------------------------------------------
module controller_frame_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        buffer_last;
    logic        out_valid;
    logic        out_ready;
    logic        frame_valid;
    logic [2:0]  frame_kind;
    logic [7:0]  button_number;
    logic        button_pressed;
    logic [23:0] color_value;
    logic [2:0]  error_code;
    logic        buffer_done;
    logic        buffer_ok;

    controller_frame_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .buffer_last    (buffer_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_valid    (frame_valid),
        .frame_kind     (frame_kind),
        .button_number  (button_number),
        .button_pressed (button_pressed),
        .color_value    (color_value),
        .error_code     (error_code),
        .buffer_done    (buffer_done),
        .buffer_ok      (buffer_ok)
    );

    // results still owed by the block, oldest first
    result_t     expected_results[$];

    // receive buffer under construction and payload of the next frame
    logic [7:0]  rx_buf[$];
    logic [7:0]  frame_body[$];

    // parser model state, mirrors the block after reset
    phase_t      scan_phase    = PH_START;
    logic [3:0]  frame_pos     = 4'd0;
    logic [3:0]  frame_len     = 4'd0;
    logic [7:0]  check_sum     = 8'd0;
    logic [2:0]  held_kind     = KIND_BUTTON;
    logic [7:0]  held_digit    = 8'd0;
    logic        held_press    = 1'b0;
    logic [23:0] held_color    = 24'd0;
    logic        buffer_failed = 1'b0;

    // idle and stall rates in percent, plus the long output hold-off
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles    = 0;

    // bookkeeping
    int          bytes_sent      = 0;
    int          buffers_sent    = 0;
    int          mismatches      = 0;
    int          frames_checked  = 0;
    int          errors_checked  = 0;
    int          buffers_checked = 0;
    int          results_checked = 0;

    result_t     seen_result;
    result_t     due_result;

    // ------------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // the timeout lies well above the slowest legal run
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // parser model: advance the state by one accepted word and tell whether
    // the block owes a result for it, and which
    // ------------------------------------------------------------------------
    task automatic predict_result(input logic [7:0] value, input logic last,
                                  output logic emit, output result_t want);
        logic [2:0] err;
        logic       good;
        err  = ERR_NONE;
        good = 1'b0;
        emit = 1'b0;
        want = '0;
        case (scan_phase)
            PH_START, PH_BETWEEN:
            begin
                // line breaks are only skipped once a frame has been seen
                if (scan_phase == PH_BETWEEN && (value == CHAR_CR || value == CHAR_LF))
                begin
                end
                else if (value == CHAR_BANG)
                begin
                    scan_phase = PH_FRAME;
                    frame_pos  = 4'd1;
                    frame_len  = 4'd0;
                    check_sum  = CHAR_BANG;
                    held_kind  = KIND_BUTTON;
                    held_digit = 8'd0;
                    held_press = 1'b0;
                    held_color = 24'd0;
                end
                else
                begin
                    err = ERR_BAD_START;
                end
            end
            PH_FRAME:
            begin
                if (frame_pos == 4'd1)
                begin
                    // type letter picks kind and total length
                    case (value)
                        CHAR_B:
                        begin
                            held_kind = KIND_BUTTON;
                            frame_len = LEN_BUTTON;
                        end
                        CHAR_C:
                        begin
                            held_kind = KIND_COLOR;
                            frame_len = LEN_COLOR;
                        end
                        CHAR_A:
                        begin
                            held_kind = KIND_ACCEL;
                            frame_len = LEN_SENSOR;
                        end
                        CHAR_M:
                        begin
                            held_kind = KIND_MAGNET;
                            frame_len = LEN_SENSOR;
                        end
                        CHAR_Q:
                        begin
                            held_kind = KIND_QUAT;
                            frame_len = LEN_QUAT;
                        end
                        CHAR_G:
                        begin
                            held_kind = KIND_GYRO;
                            frame_len = LEN_SENSOR;
                        end
                        CHAR_L:
                        begin
                            held_kind = KIND_LOC;
                            frame_len = LEN_SENSOR;
                        end
                        default:
                        begin
                            err = ERR_BAD_TYPE;
                        end
                    endcase
                    if (err == ERR_NONE)
                    begin
                        check_sum = check_sum + value;
                        frame_pos = 4'd2;
                    end
                end
                else if ({1'b0, frame_pos} + 5'd1 < {1'b0, frame_len})
                begin
                    // payload: only button and color contents are kept
                    if (held_kind == KIND_BUTTON)
                    begin
                        if (frame_pos == 4'd2)
                            held_digit = value - CHAR_ZERO;
                        else if (frame_pos == 4'd3)
                            held_press = (value == CHAR_ONE);
                    end
                    else if (held_kind == KIND_COLOR)
                    begin
                        held_color = {held_color[15:0], value};
                    end
                    check_sum = check_sum + value;
                    frame_pos = frame_pos + 4'd1;
                end
                else
                begin
                    // checksum word closes the frame
                    if (value == ~check_sum)
                    begin
                        good       = 1'b1;
                        emit       = 1'b1;
                        scan_phase = PH_BETWEEN;
                    end
                    else
                    begin
                        err = ERR_CHECKSUM;
                    end
                end
                // buffer closed inside a frame, unless the type or checksum already failed
                if (err == ERR_NONE && !good && last)
                    err = ERR_TRUNCATED;
            end
            default:
            begin
                // skipping the rest of a failed buffer
            end
        endcase

        if (err != ERR_NONE)
        begin
            buffer_failed = 1'b1;
            scan_phase    = PH_SKIP;
            emit          = 1'b1;
        end

        if (good)
        begin
            want.frame_valid = 1'b1;
            want.frame_kind  = held_kind;
            if (held_kind == KIND_BUTTON)
            begin
                want.button_number  = held_digit;
                want.button_pressed = held_press;
            end
            else if (held_kind == KIND_COLOR)
            begin
                want.color_value = held_color;
            end
        end
        want.error_code = err;

        // last word of a buffer always gives a result and rearms the parser
        if (last)
        begin
            emit             = 1'b1;
            want.buffer_done = 1'b1;
            want.buffer_ok   = !buffer_failed;
            scan_phase       = PH_START;
            frame_pos        = 4'd0;
            frame_len        = 4'd0;
            check_sum        = 8'd0;
            buffer_failed    = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // sender: offer one word, wait for it to be taken, then maybe go idle
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        logic    emit;
        result_t want;
        in_valid    <= 1'b1;
        rx_byte     <= value;
        buffer_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        predict_result(value, last, emit, want);
        if (emit)
            expected_results.push_back(want);
        bytes_sent++;
        // each cycle idles with the given chance
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // whole buffer, last flag on its final word
    task automatic send_buffer();
        foreach (rx_buf[i])
            send_byte(rx_buf[i], i == rx_buf.size() - 1);
        buffers_sent++;
    endtask

    // sender pauses until the block has given every owed result
    task automatic wait_results_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 4000)
        begin
            @(posedge clk);
            guard++;
        end
        // latency through the input and result registers, plus margin
        repeat (6) @(posedge clk);
    endtask

    // append '!', type letter, frame_body and the checksum to rx_buf
    task automatic put_frame(input logic [7:0] letter, input logic bad_sum);
        logic [7:0] total;
        logic [7:0] flip;
        total = CHAR_BANG + letter;
        flip  = 8'($urandom_range(1, 255));
        rx_buf.push_back(CHAR_BANG);
        rx_buf.push_back(letter);
        foreach (frame_body[i])
        begin
            rx_buf.push_back(frame_body[i]);
            total = total + frame_body[i];
        end
        rx_buf.push_back(bad_sum ? (~total ^ flip) : ~total);
        frame_body.delete();
    endtask

    // ------------------------------------------------------------------------
    // random buffer: mostly well-formed frame runs with random content, some
    // broken frames and some pure noise
    // ------------------------------------------------------------------------
    task automatic make_random_buffer();
        int         style;
        int         frames;
        int         n;
        int         cut;
        int         f;
        int         j;
        int         roll;
        logic [7:0] letter;
        logic [7:0] value;
        rx_buf.delete();
        style = $urandom_range(99);

        // noise, half of it opening like a frame
        if (style < 8)
        begin
            n = $urandom_range(1, 12);
            for (j = 0; j < n; j++)
                rx_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                rx_buf[0] = CHAR_BANG;
            return;
        end

        // bad opening word, line breaks included since they are not skipped here
        if (style < 12)
        begin
            value = 8'($urandom_range(255));
            if (value == CHAR_BANG || $urandom_range(1))
                value = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            rx_buf.push_back(value);
        end

        frames = $urandom_range(1, 4);
        for (f = 0; f < frames; f++)
        begin
            if (f != 0)
            begin
                n = $urandom_range(0, 2);
                repeat (n) rx_buf.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
                // stray word between frames, zero a third of the time
                if ($urandom_range(99) < 5)
                begin
                    value = 8'($urandom_range(255));
                    if ($urandom_range(2) == 0 || value == CHAR_CR || value == CHAR_LF ||
                        value == CHAR_BANG)
                        value = 8'h00;
                    rx_buf.push_back(value);
                end
            end

            case ($urandom_range(6))
                0:       letter = CHAR_B;
                1:       letter = CHAR_C;
                2:       letter = CHAR_A;
                3:       letter = CHAR_M;
                4:       letter = CHAR_Q;
                5:       letter = CHAR_G;
                default: letter = CHAR_L;
            endcase
            if ($urandom_range(99) < 5)
            begin
                // unknown type letter; all known letters sit below 0x80
                letter = 8'($urandom_range(255));
                if (letter == CHAR_B || letter == CHAR_C || letter == CHAR_A ||
                    letter == CHAR_M || letter == CHAR_Q || letter == CHAR_G ||
                    letter == CHAR_L)
                    letter = letter ^ 8'h80;
            end

            if (letter == CHAR_B)
                n = 2;
            else if (letter == CHAR_C)
                n = 3;
            else if (letter == CHAR_Q)
                n = 8;
            else
                n = 6;

            for (j = 0; j < n; j++)
            begin
                roll = $urandom_range(99);
                if (letter == CHAR_B && j == 0)
                    value = (roll < 70) ? 8'(CHAR_ZERO + $urandom_range(9)) :
                            8'($urandom_range(255));
                else if (letter == CHAR_B && j == 1)
                    value = (roll < 50) ? CHAR_ONE :
                            (roll < 75) ? CHAR_ZERO : 8'($urandom_range(255));
                else
                    value = (roll < 12) ? 8'h00 :
                            (roll < 18) ? 8'hFF : 8'($urandom_range(255));
                frame_body.push_back(value);
            end
            put_frame(letter, $urandom_range(99) < 5);
        end

        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(1, 2);
            repeat (n) rx_buf.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        end

        // buffer cut short at a random word, possibly mid-frame or right after a '!'
        if ($urandom_range(99) < 6)
        begin
            cut = $urandom_range(1, rx_buf.size());
            while (rx_buf.size() > cut)
                rx_buf.delete(rx_buf.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // button frame pressed, color frame with extreme bytes and trailing CR LF
    task automatic run_good_frames();
        rx_buf.delete();
        frame_body.push_back(8'h39);
        frame_body.push_back(CHAR_ONE);
        put_frame(CHAR_B, 1'b0);
        send_buffer();

        rx_buf.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        frame_body.push_back(8'h80);
        put_frame(CHAR_C, 1'b0);
        rx_buf.push_back(CHAR_CR);
        rx_buf.push_back(CHAR_LF);
        send_buffer();
        wait_results_drained();
    endtask

    // one buffer per error code, plus words ignored after an error
    task automatic run_error_cases();
        // CR as opening word is a bad start
        rx_buf.delete();
        rx_buf.push_back(CHAR_CR);
        send_buffer();

        // unknown type, then an ignored word closes the buffer
        rx_buf.delete();
        rx_buf.push_back(CHAR_BANG);
        rx_buf.push_back(8'h5A);
        rx_buf.push_back(8'h3F);
        send_buffer();

        // checksum mismatch on the closing word, released button
        rx_buf.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        put_frame(CHAR_B, 1'b1);
        send_buffer();

        // quaternion cut short
        rx_buf.delete();
        rx_buf.push_back(CHAR_BANG);
        rx_buf.push_back(CHAR_Q);
        rx_buf.push_back(8'h00);
        send_buffer();
        wait_results_drained();
    endtask

    // receiver holds off for a long stretch while short buffers keep coming,
    // so the result path fills and in_ready has to drop
    task automatic run_output_hold();
        int         i;
        logic [7:0] value;
        hold_cycles = 200;
        for (i = 0; i < 24; i++)
        begin
            rx_buf.delete();
            if (i % 2)
            begin
                value = 8'($urandom_range(255));
                if (value == CHAR_BANG)
                    value = 8'h00;
                rx_buf.push_back(value);
            end
            else
            begin
                frame_body.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                frame_body.push_back($urandom_range(1) ? CHAR_ONE : CHAR_ZERO);
                put_frame(CHAR_B, 1'b0);
            end
            send_buffer();
        end
        wait_results_drained();
    endtask

    // random buffers under the given idle and stall rates
    task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                      input int goal);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = bytes_sent + goal;
        while (bytes_sent < stop_at)
        begin
            make_random_buffer();
            send_buffer();
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready   <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    function automatic string show_result(input result_t r);
        return $sformatf("valid %0d kind %0d button %02h/%0d color %06h err %0d done %0d ok %0d",
                         r.frame_valid, r.frame_kind, r.button_number, r.button_pressed,
                         r.color_value, r.error_code, r.buffer_done, r.buffer_ok);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_result = {frame_valid, frame_kind, button_number, button_pressed,
                           color_value, error_code, buffer_done, buffer_ok};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: %s", $realtime,
                             show_result(seen_result));
            end
            else
            begin
                due_result = expected_results.pop_front();
                results_checked++;
                if (seen_result.frame_valid    !== due_result.frame_valid    ||
                    seen_result.frame_kind     !== due_result.frame_kind     ||
                    seen_result.button_number  !== due_result.button_number  ||
                    seen_result.button_pressed !== due_result.button_pressed ||
                    seen_result.color_value    !== due_result.color_value    ||
                    seen_result.error_code     !== due_result.error_code     ||
                    seen_result.buffer_done    !== due_result.buffer_done    ||
                    seen_result.buffer_ok      !== due_result.buffer_ok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("    expected %s", show_result(due_result));
                        $display("    actual   %s", show_result(seen_result));
                    end
                end
                if (due_result.frame_valid)
                    frames_checked++;
                if (due_result.error_code != ERR_NONE)
                    errors_checked++;
                if (due_result.buffer_done)
                    buffers_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        rx_byte     <= 8'h00;
        buffer_last <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_good_frames();
        run_error_cases();
        run_output_hold();
        // receiver stalls often first, then the sender idles often, then neither
        run_random_traffic(21, 54, 400);
        run_random_traffic(54, 21, 400);
        run_random_traffic(0, 0, 400);
        wait_results_drained();

        $display("sent %0d words in %0d receive buffers, checked %0d results",
                 bytes_sent, buffers_sent, results_checked);
        $display("good frames %0d, errors %0d, buffers closed %0d, mismatches %0d, missing %0d",
                 frames_checked, errors_checked, buffers_checked, mismatches,
                 expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
